[hdl/prf_pkg.sv]
// Package for the first-match packet rule classifier.
// Holds the beat types, rule entry layout and protocol constants.
// No dependencies.
package prf_pkg;

    typedef struct packed {
        logic        func;
        logic [5:0]  rule_index;
        logic [2:0]  word_select;
        logic [31:0] word_value;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  ip_protocol;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic        traffic_direction;
        logic        has_payload;
    } hdr_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [1:0] queue_number;
        logic       rule_hit;
        logic [5:0] hit_index;
    } res_t;

    typedef struct packed {
        logic [8:0]  control;
        logic [31:0] src_low;
        logic [31:0] src_high;
        logic [31:0] dst_low;
        logic [31:0] dst_high;
        logic [31:0] sport_range;
        logic [31:0] dport_range;
    } rule_t;

    localparam int RULE_W = $bits(rule_t);

    localparam logic FUNC_CLASSIFY = 1'b0;
    localparam logic FUNC_WRITE    = 1'b1;

    localparam logic [2:0] WSEL_CTRL     = 3'd0;
    localparam logic [2:0] WSEL_SRC_LOW  = 3'd1;
    localparam logic [2:0] WSEL_SRC_HIGH = 3'd2;
    localparam logic [2:0] WSEL_DST_LOW  = 3'd3;
    localparam logic [2:0] WSEL_DST_HIGH = 3'd4;
    localparam logic [2:0] WSEL_SPORT    = 3'd5;
    localparam logic [2:0] WSEL_DPORT    = 3'd6;
    localparam logic [2:0] WSEL_UNUSED   = 3'd7;

    localparam int CTL_ACTION    = 0;
    localparam int CTL_DIR_IN    = 1;
    localparam int CTL_DIR_OUT   = 2;
    localparam int CTL_TCP       = 3;
    localparam int CTL_UDP       = 4;
    localparam int CTL_ANY_SRC   = 5;
    localparam int CTL_ANY_DST   = 6;
    localparam int CTL_ANY_SPORT = 7;
    localparam int CTL_ANY_DPORT = 8;

    localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
    localparam logic [1:0] VERDICT_DROP   = 2'd1;
    localparam logic [1:0] VERDICT_QUEUE  = 2'd2;

    localparam logic [1:0] QUEUE_NONE = 2'd0;
    localparam logic [1:0] QUEUE_WEB  = 2'd1;
    localparam logic [1:0] QUEUE_NAME = 2'd2;

    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [31:0] LOOPBACK_ADDR = 32'h7F00_0001;
    localparam logic [15:0] WEB_PORT      = 16'd80;
    localparam logic [15:0] NAME_PORT     = 16'd53;

endpackage

[hdl/prf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module prf_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/prf_rule_match.sv]
// Match test of one rule entry against one packet header.
// Depends on prf_pkg.
module prf_rule_match (
    input  prf_pkg::hdr_t  hdr,
    input  prf_pkg::rule_t rule,
    output logic           hit
);
    import prf_pkg::*;

    logic dir_ok;
    logic proto_ok;
    logic src_ok;
    logic dst_ok;
    logic sport_ok;
    logic dport_ok;

    always_comb
    begin
        dir_ok   = hdr.traffic_direction ? rule.control[CTL_DIR_OUT]
                                         : rule.control[CTL_DIR_IN];
        proto_ok = ((hdr.ip_protocol != PROTO_TCP) || rule.control[CTL_TCP])
                && ((hdr.ip_protocol != PROTO_UDP) || rule.control[CTL_UDP]);
        src_ok   = rule.control[CTL_ANY_SRC]
                || ((hdr.src_addr >= rule.src_low) && (hdr.src_addr <= rule.src_high));
        dst_ok   = rule.control[CTL_ANY_DST]
                || ((hdr.dst_addr >= rule.dst_low) && (hdr.dst_addr <= rule.dst_high));
        sport_ok = rule.control[CTL_ANY_SPORT]
                || ((hdr.src_port >= rule.sport_range[31:16])
                    && (hdr.src_port <= rule.sport_range[15:0]));
        dport_ok = rule.control[CTL_ANY_DPORT]
                || ((hdr.dst_port >= rule.dport_range[31:16])
                    && (hdr.dst_port <= rule.dport_range[15:0]));
        hit      = dir_ok && proto_ok && src_ok && dst_ok && sport_ok && dport_ok;
    end

endmodule

[hdl/packet_rule_first_match.sv]
// Top level of the first-match packet rule classifier: control FSM,
// rule table RAM and match unit. Depends on prf_pkg, prf_ram, prf_rule_match.
//
//  channel | direction | handshake           | beat
//  hdr     | in        | hdr_valid/hdr_stall | prf_pkg::hdr_t
//  res     | out       | res_valid/res_stall | prf_pkg::res_t
//  cfg     | in        | cfg_valid/cfg_ready | rule_count, 7 bits
//
// One item at a time. A rule word write reads the entry, then writes back the
// merged entry. A packet goes through the header check, then tests the rules
// in table order; the rule table RAM gives one entry per cycle.
// Reset clears rule_count and the control state; the rule table is not
// cleared. A stalled result holds in the output register and the next item
// is accepted meanwhile; a new result waits until that register is free.
module packet_rule_first_match #(
    parameter int MAX_RULES = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           hdr_valid,
    output logic           hdr_stall,
    input  prf_pkg::hdr_t  hdr_data,
    output logic           res_valid,
    input  logic           res_stall,
    output prf_pkg::res_t  res_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [6:0]     cfg_data
);
    import prf_pkg::*;

    localparam int AW   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNTW = $clog2(MAX_RULES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_CHECK,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t          state_reg, state_next;
    hdr_t            hdr_reg, hdr_next;
    res_t            pend_reg, pend_next;
    res_t            res_reg, res_next;
    logic            res_valid_reg, res_valid_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [CNTW-1:0] limit_reg, limit_next;

    logic            ram_wr_en;
    logic [AW-1:0]   ram_wr_addr;
    rule_t           ram_wr_data;
    logic            ram_rd_en;
    logic [AW-1:0]   ram_rd_addr;
    rule_t           ram_rd_data;
    logic            rule_hit;

    logic            hdr_fire;
    logic            res_free;
    logic            index_ok;
    logic [AW+5:0]   in_idx_wide;
    logic [AW+5:0]   reg_idx_wide;
    logic [CNTW-1:0] idx_succ;
    logic            is_tcp;
    logic            is_udp;
    rule_t           merged;

    prf_ram #(
        .WIDTH (RULE_W),
        .DEPTH (MAX_RULES)
    ) u_rule_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    prf_rule_match u_match (
        .hdr  (hdr_reg),
        .rule (ram_rd_data),
        .hit  (rule_hit)
    );

    assign hdr_stall = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    assign hdr_fire     = hdr_valid && !hdr_stall;
    assign res_free     = !res_valid_reg || !res_stall;
    assign in_idx_wide  = {{AW{1'b0}}, hdr_data.rule_index};
    assign reg_idx_wide = {{AW{1'b0}}, hdr_reg.rule_index};
    assign index_ok     = ({26'd0, hdr_data.rule_index} < 32'(MAX_RULES));
    assign idx_succ     = CNTW'(idx_reg) + 1'b1;
    assign is_tcp       = (hdr_reg.ip_protocol == PROTO_TCP);
    assign is_udp       = (hdr_reg.ip_protocol == PROTO_UDP);

    // merge the new word into the entry read back
    always_comb
    begin
        merged = ram_rd_data;
        unique case (hdr_reg.word_select)
            WSEL_CTRL:     merged.control     = hdr_reg.word_value[8:0];
            WSEL_SRC_LOW:  merged.src_low     = hdr_reg.word_value;
            WSEL_SRC_HIGH: merged.src_high    = hdr_reg.word_value;
            WSEL_DST_LOW:  merged.dst_low     = hdr_reg.word_value;
            WSEL_DST_HIGH: merged.dst_high    = hdr_reg.word_value;
            WSEL_SPORT:    merged.sport_range = hdr_reg.word_value;
            WSEL_DPORT:    merged.dport_range = hdr_reg.word_value;
            default:       merged             = ram_rd_data;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        hdr_next       = hdr_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        idx_next       = idx_reg;
        limit_next     = limit_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = reg_idx_wide[AW-1:0];
        ram_wr_data    = merged;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = in_idx_wide[AW-1:0];

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            if ({25'd0, cfg_data} > 32'(MAX_RULES))
            begin
                limit_next = CNTW'(MAX_RULES);
            end
            else
            begin
                limit_next = CNTW'(cfg_data);
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (hdr_fire)
                begin
                    hdr_next = hdr_data;
                    if (hdr_data.func == FUNC_CLASSIFY)
                    begin
                        state_next = ST_CHECK;
                    end
                    else if (index_ok)
                    begin
                        ram_rd_en  = 1'b1;
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE:
            begin
                ram_wr_en  = (hdr_reg.word_select != WSEL_UNUSED);
                state_next = ST_IDLE;
            end
            ST_CHECK:
            begin
                pend_next  = '{VERDICT_ACCEPT, QUEUE_NONE, 1'b0, 6'd0};
                state_next = ST_FINISH;
                priority if (!is_tcp && !is_udp)
                begin
                    pend_next = '{VERDICT_ACCEPT, QUEUE_NONE, 1'b0, 6'd0};
                end
                else if (hdr_reg.dst_addr == LOOPBACK_ADDR)
                begin
                    pend_next = '{VERDICT_ACCEPT, QUEUE_NONE, 1'b0, 6'd0};
                end
                else if (is_tcp && hdr_reg.dst_port == WEB_PORT && hdr_reg.has_payload)
                begin
                    pend_next = '{VERDICT_QUEUE, QUEUE_WEB, 1'b0, 6'd0};
                end
                else if (is_udp && (hdr_reg.src_port == NAME_PORT
                                    || hdr_reg.dst_port == NAME_PORT))
                begin
                    pend_next = '{VERDICT_QUEUE, QUEUE_NAME, 1'b0, 6'd0};
                end
                else if (limit_reg != '0)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = '0;
                    idx_next    = '0;
                    state_next  = ST_SCAN;
                end
                else
                begin
                    pend_next = '{VERDICT_ACCEPT, QUEUE_NONE, 1'b0, 6'd0};
                end
            end
            ST_SCAN:
            begin
                priority if (rule_hit)
                begin
                    pend_next = '{{1'b0, ram_rd_data.control[CTL_ACTION]}, QUEUE_NONE,
                                  1'b1, 6'(idx_reg)};
                    state_next = ST_FINISH;
                end
                else if (idx_succ == limit_reg)
                begin
                    pend_next  = '{VERDICT_ACCEPT, QUEUE_NONE, 1'b0, 6'd0};
                    state_next = ST_FINISH;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_succ[AW-1:0];
                    idx_next    = idx_succ[AW-1:0];
                end
            end
            ST_FINISH:
            begin
                if (res_free)
                begin
                    res_next       = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hdr_reg       <= '0;
            pend_reg      <= '0;
            res_reg       <= '0;
            res_valid_reg <= 1'b0;
            idx_reg       <= '0;
            limit_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hdr_reg       <= hdr_next;
            pend_reg      <= pend_next;
            res_reg       <= res_next;
            res_valid_reg <= res_valid_next;
            idx_reg       <= idx_next;
            limit_reg     <= limit_next;
        end
    end

    a_classify_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_fire && hdr_data.func == FUNC_CLASSIFY |=> state_reg == ST_CHECK)
        else $error("classify beat did not enter header check");

    a_scan_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> CNTW'(idx_reg) < limit_reg)
        else $error("scan index beyond rule count");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result loaded outside finish");

    a_hit_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_reg.rule_hit || res_reg.hit_index == 6'd0)
        else $error("hit index set without rule hit");

    a_queue_only_on_queue: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.queue_number != QUEUE_NONE
            |-> res_reg.verdict == VERDICT_QUEUE && !res_reg.rule_hit)
        else $error("queue number without queue verdict");

endmodule

[dv/prf_checker.sv]
`timescale 1ns / 100ps
// Checker for the first-match packet rule classifier: watches the hdr, cfg
// and res channels, predicts each verdict from its own rule table copy and
// compares it with the result beats. Depends on prf_pkg.
module prf_checker #(
    parameter int MAX_RULES = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          hdr_valid,
    input  logic          hdr_stall,
    input  prf_pkg::hdr_t hdr_data,
    input  logic          res_valid,
    input  logic          res_stall,
    input  prf_pkg::res_t res_data,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [6:0]    cfg_data,
    output int            mismatch_count,
    output int            results_owed
);
    import prf_pkg::*;

    rule_t      acl [MAX_RULES];
    logic [6:0] active_rules;
    res_t       verdict_q [$];
    int         errors_seen = 0;
    int         owed = 0;

    assign mismatch_count = errors_seen;
    assign results_owed   = owed;

    function automatic res_t predict_verdict(input hdr_t p);
        res_t        r;
        rule_t       e;
        logic        is_tcp;
        logic        is_udp;
        int unsigned reach;
        r      = '0;
        is_tcp = (p.ip_protocol == PROTO_TCP);
        is_udp = (p.ip_protocol == PROTO_UDP);
        if (!is_tcp && !is_udp)
            return r;
        if (p.dst_addr == LOOPBACK_ADDR)
            return r;
        if (is_tcp && p.dst_port == WEB_PORT && p.has_payload)
        begin
            r.verdict      = VERDICT_QUEUE;
            r.queue_number = QUEUE_WEB;
            return r;
        end
        if (is_udp && (p.src_port == NAME_PORT || p.dst_port == NAME_PORT))
        begin
            r.verdict      = VERDICT_QUEUE;
            r.queue_number = QUEUE_NAME;
            return r;
        end
        reach = (active_rules > MAX_RULES) ? MAX_RULES : active_rules;
        for (int i = 0; i < reach; i++)
        begin
            e = acl[i];
            if (!e.control[CTL_DIR_IN + p.traffic_direction])
                continue;
            if (is_tcp && !e.control[CTL_TCP])
                continue;
            if (is_udp && !e.control[CTL_UDP])
                continue;
            if (!e.control[CTL_ANY_SRC]
                && (p.src_addr < e.src_low || p.src_addr > e.src_high))
                continue;
            if (!e.control[CTL_ANY_DST]
                && (p.dst_addr < e.dst_low || p.dst_addr > e.dst_high))
                continue;
            if (!e.control[CTL_ANY_SPORT]
                && (p.src_port < e.sport_range[31:16] || p.src_port > e.sport_range[15:0]))
                continue;
            if (!e.control[CTL_ANY_DPORT]
                && (p.dst_port < e.dport_range[31:16] || p.dst_port > e.dport_range[15:0]))
                continue;
            r.verdict   = e.control[CTL_ACTION] ? VERDICT_DROP : VERDICT_ACCEPT;
            r.rule_hit  = 1'b1;
            r.hit_index = 6'(i);
            return r;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t       want;
        logic [5:0] slot;
        if (!rst_n)
        begin
            verdict_q.delete();
            active_rules = '0;
            owed         = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    errors_seen++;
                    $error("result beat with no prediction pending: %p", res_data);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (res_data.verdict !== want.verdict)
                    begin
                        errors_seen++;
                        $error("verdict: expected %0d, got %0d",
                               want.verdict, res_data.verdict);
                    end
                    if (res_data.queue_number !== want.queue_number)
                    begin
                        errors_seen++;
                        $error("queue_number: expected %0d, got %0d",
                               want.queue_number, res_data.queue_number);
                    end
                    if (res_data.rule_hit !== want.rule_hit)
                    begin
                        errors_seen++;
                        $error("rule_hit: expected %0d, got %0d",
                               want.rule_hit, res_data.rule_hit);
                    end
                    if (res_data.hit_index !== want.hit_index)
                    begin
                        errors_seen++;
                        $error("hit_index: expected %0d, got %0d",
                               want.hit_index, res_data.hit_index);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                active_rules = cfg_data;
            if (hdr_valid && !hdr_stall)
            begin
                if (hdr_data.func == FUNC_WRITE)
                begin
                    slot = hdr_data.rule_index;
                    case (hdr_data.word_select)
                        WSEL_CTRL:     acl[slot].control     = hdr_data.word_value[8:0];
                        WSEL_SRC_LOW:  acl[slot].src_low     = hdr_data.word_value;
                        WSEL_SRC_HIGH: acl[slot].src_high    = hdr_data.word_value;
                        WSEL_DST_LOW:  acl[slot].dst_low     = hdr_data.word_value;
                        WSEL_DST_HIGH: acl[slot].dst_high    = hdr_data.word_value;
                        WSEL_SPORT:    acl[slot].sport_range = hdr_data.word_value;
                        WSEL_DPORT:    acl[slot].dport_range = hdr_data.word_value;
                        default:       ;
                    endcase
                end
                else
                    verdict_q.push_back(predict_verdict(hdr_data));
            end
            owed = verdict_q.size();
        end
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Top of the classifier testbench: clock, reset, header and config stimulus,
// result stall, and the final verdict. Depends on prf_pkg, prf_checker and
// packet_rule_first_match.
module testbench;
    import prf_pkg::*;

    localparam int RULE_DEPTH = 64;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       hdr_valid = 1'b0;
    logic       hdr_stall;
    hdr_t       hdr_data = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    res_t       res_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [6:0] cfg_data = '0;
    logic       quiet = 1'b0;
    int         mismatch_count;
    int         results_owed;

    rule_t rule_image [RULE_DEPTH];

    packet_rule_first_match #(
        .MAX_RULES(RULE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr_stall (hdr_stall),
        .hdr_data  (hdr_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    prf_checker #(
        .MAX_RULES(RULE_DEPTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .hdr_valid      (hdr_valid),
        .hdr_stall      (hdr_stall),
        .hdr_data       (hdr_data),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res_data       (res_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        res_stall <= !quiet && ($urandom_range(0, 99) < 25);

    initial
    begin
        #(2_000_000);
        $display("[packet_rule_first_match] ERROR");
        $finish;
    end

    task automatic push_hdr(input hdr_t beat);
        while (!quiet && $urandom_range(0, 99) < 25)
        begin
            hdr_valid <= 1'b0;
            @(posedge clk);
        end
        hdr_valid <= 1'b1;
        hdr_data  <= beat;
        @(posedge clk);
        while (hdr_stall)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        hdr_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (RULE_DEPTH + 8) @(posedge clk);
    endtask

    task automatic set_rule_count(input logic [6:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_word(input logic [5:0] idx, input logic [2:0] sel,
                              input logic [31:0] value);
        hdr_t beat;
        beat             = hdr_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        beat.func        = FUNC_WRITE;
        beat.rule_index  = idx;
        beat.word_select = sel;
        beat.word_value  = value;
        case (sel)
            WSEL_CTRL:     rule_image[idx].control     = value[8:0];
            WSEL_SRC_LOW:  rule_image[idx].src_low     = value;
            WSEL_SRC_HIGH: rule_image[idx].src_high    = value;
            WSEL_DST_LOW:  rule_image[idx].dst_low     = value;
            WSEL_DST_HIGH: rule_image[idx].dst_high    = value;
            WSEL_SPORT:    rule_image[idx].sport_range = value;
            WSEL_DPORT:    rule_image[idx].dport_range = value;
            default:       ;
        endcase
        push_hdr(beat);
    endtask

    task automatic write_rule(input logic [5:0] idx, input rule_t r);
        write_word(idx, WSEL_CTRL, 32'(r.control));
        write_word(idx, WSEL_SRC_LOW, r.src_low);
        write_word(idx, WSEL_SRC_HIGH, r.src_high);
        write_word(idx, WSEL_DST_LOW, r.dst_low);
        write_word(idx, WSEL_DST_HIGH, r.dst_high);
        write_word(idx, WSEL_SPORT, r.sport_range);
        write_word(idx, WSEL_DPORT, r.dport_range);
    endtask

    function automatic logic [63:0] make_bounds(input logic [31:0] full,
                                                input int unsigned max_shift);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [32:0] sum;
        lo = $urandom & full;
        case ($urandom_range(0, 9))
            0:
            begin
                lo = '0;
                hi = full;
            end
            1: hi = lo;
            2:
            begin
                if (lo == '0)
                    lo = 32'd1;
                hi = lo - 32'd1;
            end
            default:
            begin
                sum = {1'b0, lo} + 33'($urandom & ((33'd1 << $urandom_range(0, max_shift)) - 1));
                hi  = (sum > {1'b0, full}) ? full : sum[31:0];
            end
        endcase
        return {lo, hi};
    endfunction

    function automatic rule_t make_rule();
        rule_t       r;
        logic [63:0] bounds;
        r.control = 9'($urandom);
        for (int b = CTL_ANY_SRC; b <= CTL_ANY_DPORT; b++)
            r.control[b] = ($urandom_range(0, 4) == 0);
        bounds        = make_bounds(32'hFFFF_FFFF, 24);
        r.src_low     = bounds[63:32];
        r.src_high    = bounds[31:0];
        bounds        = make_bounds(32'hFFFF_FFFF, 24);
        r.dst_low     = bounds[63:32];
        r.dst_high    = bounds[31:0];
        bounds        = make_bounds(32'h0000_FFFF, 12);
        r.sport_range = {bounds[47:32], bounds[15:0]};
        bounds        = make_bounds(32'h0000_FFFF, 12);
        r.dport_range = {bounds[47:32], bounds[15:0]};
        return r;
    endfunction

    function automatic logic [31:0] pick_in(input logic [31:0] lo, input logic [31:0] hi);
        logic [32:0] span;
        if (lo > hi)
            return $urandom;
        span = {1'b0, hi} - {1'b0, lo} + 33'd1;
        return lo + 32'({1'b0, $urandom} % span);
    endfunction

    function automatic hdr_t packet(input logic [7:0] proto, input logic [31:0] sa,
                                    input logic [31:0] da, input logic [15:0] sp,
                                    input logic [15:0] dp, input logic dir,
                                    input logic payload);
        hdr_t p;
        p                   = hdr_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        p.func              = FUNC_CLASSIFY;
        p.ip_protocol       = proto;
        p.src_addr          = sa;
        p.dst_addr          = da;
        p.src_port          = sp;
        p.dst_port          = dp;
        p.traffic_direction = dir;
        p.has_payload       = payload;
        return p;
    endfunction

    function automatic hdr_t make_packet(input int unsigned reach);
        hdr_t  p;
        rule_t r;
        p = packet($urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP, $urandom, $urandom,
                   16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
        case ($urandom_range(0, 11))
            0: p.ip_protocol = 8'($urandom);
            1: p.dst_addr = LOOPBACK_ADDR;
            2:
            begin
                p.ip_protocol = PROTO_TCP;
                p.dst_port    = WEB_PORT;
            end
            3:
            begin
                p.ip_protocol = PROTO_UDP;
                if ($urandom_range(0, 1))
                    p.src_port = NAME_PORT;
                else
                    p.dst_port = NAME_PORT;
            end
            4: ;
            default:
            begin
                if (reach > 0)
                begin
                    r = rule_image[$urandom_range(0, reach - 1)];
                    case (r.control[CTL_DIR_OUT:CTL_DIR_IN])
                        2'b01:   p.traffic_direction = 1'b0;
                        2'b10:   p.traffic_direction = 1'b1;
                        default: ;
                    endcase
                    case (r.control[CTL_UDP:CTL_TCP])
                        2'b01:   p.ip_protocol = PROTO_TCP;
                        2'b10:   p.ip_protocol = PROTO_UDP;
                        default: ;
                    endcase
                    p.src_addr = pick_in(r.src_low, r.src_high);
                    p.dst_addr = pick_in(r.dst_low, r.dst_high);
                    p.src_port = 16'(pick_in(32'(r.sport_range[31:16]),
                                             32'(r.sport_range[15:0])));
                    p.dst_port = 16'(pick_in(32'(r.dport_range[31:16]),
                                             32'(r.dport_range[15:0])));
                end
            end
        endcase
        return p;
    endfunction

    initial
    begin
        int unsigned counts[$];
        int unsigned reach;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: fast paths and default accept
        set_rule_count(7'd0);
        push_hdr(packet(PROTO_TCP, 32'h0A00_0001, 32'hC0A8_0001, 16'd1234, 16'd443, 1'b0, 1'b1));
        push_hdr(packet(8'd0, $urandom, $urandom, 16'd53, 16'd80, 1'b1, 1'b1));
        push_hdr(packet(8'd255, $urandom, $urandom, 16'hFFFF, 16'h0000, 1'b0, 1'b0));
        push_hdr(packet(PROTO_TCP, 32'hFFFF_FFFF, LOOPBACK_ADDR, 16'd1, WEB_PORT, 1'b0, 1'b1));
        push_hdr(packet(PROTO_TCP, 32'h0000_0000, 32'h0808_0808, 16'hFFFF, WEB_PORT, 1'b1, 1'b1));
        push_hdr(packet(PROTO_TCP, 32'h0000_0000, 32'h0808_0808, 16'd0, WEB_PORT, 1'b1, 1'b0));
        push_hdr(packet(PROTO_UDP, $urandom, 32'h0808_0404, NAME_PORT, 16'd9999, 1'b0, 1'b0));
        push_hdr(packet(PROTO_UDP, $urandom, 32'h0808_0404, 16'd40000, NAME_PORT, 1'b1, 1'b0));
        push_hdr(packet(PROTO_UDP, $urandom, LOOPBACK_ADDR, 16'd40000, NAME_PORT, 1'b1, 1'b0));
        write_word(6'd0, WSEL_UNUSED, $urandom);

        // one drop rule on inbound TCP, then an inverted port range
        write_word(6'd0, WSEL_CTRL, (32'd1 << CTL_ACTION) | (32'd1 << CTL_DIR_IN)
                                    | (32'd1 << CTL_TCP));
        write_word(6'd0, WSEL_SRC_LOW, 32'h0A00_0000);
        write_word(6'd0, WSEL_SRC_HIGH, 32'h0A00_00FF);
        write_word(6'd0, WSEL_DST_LOW, 32'h0000_0000);
        write_word(6'd0, WSEL_DST_HIGH, 32'hFFFF_FFFF);
        write_word(6'd0, WSEL_SPORT, 32'h0000_FFFF);
        write_word(6'd0, WSEL_DPORT, {16'd1000, 16'd2000});
        set_rule_count(7'd1);
        push_hdr(packet(PROTO_TCP, 32'h0A00_0010, 32'hC0A8_0001, 16'd5000, 16'd1500, 1'b0, 1'b1));
        push_hdr(packet(PROTO_TCP, 32'h0A00_0010, 32'hC0A8_0001, 16'd5000, 16'd1500, 1'b1, 1'b1));
        push_hdr(packet(PROTO_UDP, 32'h0A00_0010, 32'hC0A8_0001, 16'd5000, 16'd1500, 1'b0, 1'b0));
        push_hdr(packet(PROTO_TCP, 32'h0A00_0010, 32'hC0A8_0001, 16'd5000, 16'd2001, 1'b0, 1'b0));
        push_hdr(packet(PROTO_TCP, 32'h0A00_0000, 32'h0000_0000, 16'h0000, 16'd1000, 1'b0, 1'b0));
        push_hdr(packet(PROTO_TCP, 32'h0A00_00FF, 32'hFFFF_FFFE, 16'hFFFF, 16'd2000, 1'b0, 1'b1));
        write_word(6'd0, WSEL_DPORT, {16'd2000, 16'd1000});
        push_hdr(packet(PROTO_TCP, 32'h0A00_0010, 32'hC0A8_0001, 16'd5000, 16'd1500, 1'b0, 1'b0));

        // fill the whole table, classifying against entry 0 in between
        for (int idx = 0; idx < RULE_DEPTH; idx++)
        begin
            write_rule(6'(idx), make_rule());
            push_hdr(make_packet(1));
        end

        counts = '{64, 127, 1, $urandom_range(2, 63), $urandom_range(65, 126), 0, 64};
        foreach (counts[k])
        begin
            quiet <= (k == 1);
            set_rule_count(7'(counts[k]));
            reach = (counts[k] > RULE_DEPTH) ? RULE_DEPTH : counts[k];
            repeat (130)
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    if ($urandom_range(0, 2) == 0)
                        write_rule(6'($urandom), make_rule());
                    else
                        write_word(6'($urandom), 3'($urandom), $urandom);
                end
                else
                    push_hdr(make_packet(reach));
            end
        end

        quiet <= 1'b0;
        wait_idle();
        if (mismatch_count == 0)
            $display("[packet_rule_first_match] OK");
        else
            $display("[packet_rule_first_match] ERROR");
        $finish;
    end

endmodule
